// ===== design/pod_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pod_pkg: shared types and constants of the priority ordered deque
// Command and status codes, default sizes, and the control and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pod_pkg;

  localparam int unsigned DEPTH_DEF          = 16;
  localparam int unsigned PAYLOAD_WIDTH_DEF  = 16;
  localparam int unsigned PRIORITY_WIDTH_DEF = 16;
  localparam int unsigned CMD_WIDTH          = 3;
  localparam int unsigned STATUS_WIDTH       = 2;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_INS_TAIL = 3'd0,
    CMD_INS_HEAD = 3'd1,
    CMD_INS_PRIO = 3'd2,
    CMD_REM_HEAD = 3'd3,
    CMD_REM_TAIL = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } stat_e;

  // Read address sources of the entry memory.
  typedef enum logic [1:0] {
    RD_POS,
    RD_SHIFT,
    RD_HEAD,
    RD_TAIL
  } rd_sel_e;

  // Write address sources of the entry memory.
  typedef enum logic [1:0] {
    WR_TAIL,
    WR_HEAD,
    WR_POS,
    WR_SHIFT
  } wr_sel_e;

  typedef struct packed {
    logic    in_ready;
    logic    pos_inc;
    logic    k_load;
    logic    k_dec;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    commit;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic empty;
    logic greater;
    logic scan_last;
    logic shift_last;
    logic out_free;
  } ctrl_stat_t;

endpackage

// ===== design/pod_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pod_in_if: command channel of the priority ordered deque
// One word carries a command, a payload and a signed priority.
// ----------------------------------------------------------------------------
interface pod_in_if #(
  parameter int unsigned PAYLOAD_WIDTH  = pod_pkg::PAYLOAD_WIDTH_DEF,
  parameter int unsigned PRIORITY_WIDTH = pod_pkg::PRIORITY_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic [pod_pkg::CMD_WIDTH-1:0]     command;
  logic [PAYLOAD_WIDTH-1:0]          payload;
  logic signed [PRIORITY_WIDTH-1:0]  priority_req;

  modport source (output valid, output command, output payload, output priority_req,
                  input ready);
  modport sink   (input valid, input command, input payload, input priority_req,
                  output ready);
endinterface

// ===== design/pod_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pod_out_if: result channel of the priority ordered deque
// One word reports the removed payload, a status and the fill level.
// ----------------------------------------------------------------------------
interface pod_out_if #(
  parameter int unsigned DEPTH         = pod_pkg::DEPTH_DEF,
  parameter int unsigned PAYLOAD_WIDTH = pod_pkg::PAYLOAD_WIDTH_DEF
);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                             valid;
  logic                             ready;
  logic [PAYLOAD_WIDTH-1:0]         removed_payload;
  logic                             removed_valid;
  logic [pod_pkg::STATUS_WIDTH-1:0] status;
  logic [CW-1:0]                    entry_count;
  logic                             list_empty;

  modport source (output valid, output removed_payload, output removed_valid,
                  output status, output entry_count, output list_empty, input ready);
  modport sink   (input valid, input removed_payload, input removed_valid,
                  input status, input entry_count, input list_empty, output ready);
endinterface

// ===== design/pod_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pod_ctrl: sequencer of the priority ordered deque
// Steps commands via decode and commit; priority inserts scan, shift, place.
// ----------------------------------------------------------------------------
module pod_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  pod_pkg::ctrl_stat_t stat_i,
  output pod_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.rd_sel = pod_pkg::RD_POS;
    cmd_o.wr_sel = pod_pkg::WR_TAIL;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINISH;
        unique case (stat_i.cmd)
          pod_pkg::CMD_INS_TAIL: begin
            cmd_o.wr_en  = !stat_i.full;
            cmd_o.wr_sel = pod_pkg::WR_TAIL;
          end
          pod_pkg::CMD_INS_HEAD: begin
            cmd_o.wr_en  = !stat_i.full;
            cmd_o.wr_sel = pod_pkg::WR_HEAD;
          end
          pod_pkg::CMD_INS_PRIO: begin
            if (stat_i.empty) begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wr_sel = pod_pkg::WR_TAIL;
            end else if (!stat_i.full) begin
              state_d = S_SCAN_RD;
            end
          end
          pod_pkg::CMD_REM_HEAD: begin
            cmd_o.rd_en  = !stat_i.empty;
            cmd_o.rd_sel = pod_pkg::RD_HEAD;
          end
          pod_pkg::CMD_REM_TAIL: begin
            cmd_o.rd_en  = !stat_i.empty;
            cmd_o.rd_sel = pod_pkg::RD_TAIL;
          end
          default: begin
          end
        endcase
      end
      S_SCAN_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = pod_pkg::RD_POS;
        state_d      = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (stat_i.greater) begin
          cmd_o.pos_inc = 1'b1;
          state_d       = stat_i.scan_last ? S_PLACE : S_SCAN_RD;
        end else begin
          cmd_o.k_load = 1'b1;
          state_d      = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = pod_pkg::RD_SHIFT;
        state_d      = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = pod_pkg::WR_SHIFT;
        cmd_o.k_dec  = 1'b1;
        state_d      = stat_i.shift_last ? S_PLACE : S_SHIFT_RD;
      end
      S_PLACE: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = pod_pkg::WR_POS;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  property p_commit_from_finish;
    @(posedge clk_i) disable iff (!rst_ni)
      cmd_o.commit |=> (state_q == S_IDLE);
  endproperty
  a_commit_from_finish: assert property (p_commit_from_finish)
    else $error("commit did not return the sequencer to idle");

  property p_shift_then_place;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_SHIFT_WR) && stat_i.shift_last |=> (state_q == S_PLACE);
  endproperty
  a_shift_then_place: assert property (p_shift_then_place)
    else $error("last shift step was not followed by placing the new entry");

  property p_accept_only_idle;
    @(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && cmd_o.in_ready |=> (state_q == S_DECODE);
  endproperty
  a_accept_only_idle: assert property (p_accept_only_idle)
    else $error("accepted word was not decoded in the next cycle");

endmodule

// ===== design/pod_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pod_dp: datapath of the priority ordered deque
// Circular entry memory with head pointer and count, scan and shift cursors,
// the held command word and the result register.
// ----------------------------------------------------------------------------
module pod_dp #(
  parameter int unsigned DEPTH          = pod_pkg::DEPTH_DEF,
  parameter int unsigned PAYLOAD_WIDTH  = pod_pkg::PAYLOAD_WIDTH_DEF,
  parameter int unsigned PRIORITY_WIDTH = pod_pkg::PRIORITY_WIDTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic [pod_pkg::CMD_WIDTH-1:0]    in_command_i,
  input  logic [PAYLOAD_WIDTH-1:0]         in_payload_i,
  input  logic signed [PRIORITY_WIDTH-1:0] in_priority_i,
  input  pod_pkg::ctrl_cmd_t               ctl_i,
  output pod_pkg::ctrl_stat_t              stat_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [PAYLOAD_WIDTH-1:0]         out_removed_payload_o,
  output logic                             out_removed_valid_o,
  output logic [pod_pkg::STATUS_WIDTH-1:0] out_status_o,
  output logic [CW-1:0]                    out_entry_count_o,
  output logic                             out_list_empty_o
);

  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
  localparam logic [AW:0]   WRAP       = (AW + 1)'(DEPTH);

  logic [PAYLOAD_WIDTH-1:0]         mem_pay [DEPTH];
  logic signed [PRIORITY_WIDTH-1:0] mem_pri [DEPTH];

  pod_pkg::cmd_e                    cmd_q;
  logic [PAYLOAD_WIDTH-1:0]         pay_q;
  logic signed [PRIORITY_WIDTH-1:0] pri_q;
  logic [PAYLOAD_WIDTH-1:0]         rd_pay_q;
  logic signed [PRIORITY_WIDTH-1:0] rd_pri_q;
  logic [CW-1:0]                    count_q, count_d;
  logic [AW-1:0]                    head_q, head_d;
  logic [CW-1:0]                    pos_q, k_q;
  logic                             out_valid_q;
  logic [PAYLOAD_WIDTH-1:0]         out_pay_q;
  logic                             out_rv_q;
  pod_pkg::stat_e                   out_status_q;
  logic [CW-1:0]                    out_count_q;

  logic                             accept;
  logic                             is_ins, is_rem, full, empty;
  logic [AW-1:0]                    head_dec, head_inc;
  logic [CW-1:0]                    pos_nxt, k_prev, count_prev;
  logic [AW-1:0]                    rd_addr, wr_addr;
  logic [PAYLOAD_WIDTH-1:0]         wr_pay;
  logic signed [PRIORITY_WIDTH-1:0] wr_pri;
  pod_pkg::stat_e                   status_d;

  // Logical place to memory slot, counted from the head with wrap-around.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] idx);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= WRAP) begin
      sum = sum - WRAP;
    end
    return sum[AW-1:0];
  endfunction

  assign accept     = in_valid_i && ctl_i.in_ready;
  assign full       = (count_q == FULL_COUNT);
  assign empty      = (count_q == '0);
  assign head_dec   = (head_q == '0) ? LAST_SLOT : head_q - 1'b1;
  assign head_inc   = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
  assign pos_nxt    = pos_q + 1'b1;
  assign k_prev     = k_q - 1'b1;
  assign count_prev = count_q - 1'b1;

  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    case (cmd_q) inside
      pod_pkg::CMD_INS_TAIL, pod_pkg::CMD_INS_HEAD, pod_pkg::CMD_INS_PRIO: is_ins = 1'b1;
      pod_pkg::CMD_REM_HEAD, pod_pkg::CMD_REM_TAIL:                        is_rem = 1'b1;
      default: begin
      end
    endcase
  end

  always_comb begin
    stat_o            = '0;
    stat_o.cmd        = cmd_q;
    stat_o.full       = full;
    stat_o.empty      = empty;
    stat_o.greater    = (pri_q > rd_pri_q);
    stat_o.scan_last  = (pos_nxt == count_q);
    stat_o.shift_last = (k_prev == pos_q);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    case (ctl_i.rd_sel)
      pod_pkg::RD_POS:   rd_addr = phys(head_q, pos_q[AW-1:0]);
      pod_pkg::RD_SHIFT: rd_addr = phys(head_q, k_prev[AW-1:0]);
      pod_pkg::RD_HEAD:  rd_addr = head_q;
      pod_pkg::RD_TAIL:  rd_addr = phys(head_q, count_prev[AW-1:0]);
      default:           rd_addr = head_q;
    endcase
  end

  always_comb begin
    wr_pay = pay_q;
    wr_pri = pri_q;
    case (ctl_i.wr_sel)
      pod_pkg::WR_TAIL:  wr_addr = phys(head_q, count_q[AW-1:0]);
      pod_pkg::WR_HEAD:  wr_addr = head_dec;
      pod_pkg::WR_POS:   wr_addr = phys(head_q, pos_q[AW-1:0]);
      pod_pkg::WR_SHIFT: begin
        wr_addr = phys(head_q, k_q[AW-1:0]);
        wr_pay  = rd_pay_q;
        wr_pri  = rd_pri_q;
      end
      default:           wr_addr = head_q;
    endcase
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_pay[wr_addr] <= wr_pay;
      mem_pri[wr_addr] <= wr_pri;
    end
    if (ctl_i.rd_en) begin
      rd_pay_q <= mem_pay[rd_addr];
      rd_pri_q <= mem_pri[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= pod_pkg::cmd_e'(in_command_i);
      pay_q <= in_payload_i;
      pri_q <= in_priority_i;
    end
  end

  always_comb begin
    count_d  = count_q;
    head_d   = head_q;
    status_d = pod_pkg::ST_DONE;
    if (is_ins) begin
      if (full) begin
        status_d = pod_pkg::ST_FULL;
      end else begin
        count_d = count_q + 1'b1;
        if (cmd_q == pod_pkg::CMD_INS_HEAD) begin
          head_d = head_dec;
        end
      end
    end else if (is_rem) begin
      if (empty) begin
        status_d = pod_pkg::ST_EMPTY;
      end else begin
        count_d = count_prev;
        if (cmd_q == pod_pkg::CMD_REM_HEAD) begin
          head_d = head_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      head_q      <= '0;
      pos_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q <= '0;
      end else if (ctl_i.pos_inc) begin
        pos_q <= pos_nxt;
      end
      if (ctl_i.k_load) begin
        k_q <= count_q;
      end else if (ctl_i.k_dec) begin
        k_q <= k_prev;
      end
      if (ctl_i.commit) begin
        count_q     <= count_d;
        head_q      <= head_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      out_rv_q     <= is_rem && !empty;
      out_pay_q    <= (is_rem && !empty) ? rd_pay_q : '0;
      out_status_q <= status_d;
      out_count_q  <= count_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_removed_payload_o = out_pay_q;
  assign out_removed_valid_o   = out_rv_q;
  assign out_status_o          = out_status_q;
  assign out_entry_count_o     = out_count_q;
  assign out_list_empty_o      = (out_count_q == '0);

  property p_count_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      count_q <= FULL_COUNT;
  endproperty
  a_count_bound: assert property (p_count_bound)
    else $error("entry count exceeds the depth");

  property p_head_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      head_q <= LAST_SLOT;
  endproperty
  a_head_bound: assert property (p_head_bound)
    else $error("head pointer outside the memory");

  property p_shift_above_pos;
    @(posedge clk_i) disable iff (!rst_ni)
      ctl_i.wr_en && (ctl_i.wr_sel == pod_pkg::WR_SHIFT) |-> (k_q > pos_q) && !full;
  endproperty
  a_shift_above_pos: assert property (p_shift_above_pos)
    else $error("shift step at or below the insertion place");

  property p_remove_decrements;
    @(posedge clk_i) disable iff (!rst_ni)
      ctl_i.commit && is_rem && !empty |=> count_q == $past(count_prev);
  endproperty
  a_remove_decrements: assert property (p_remove_decrements)
    else $error("successful removal did not lower the count by one");

endmodule

// ===== design/priority_ordered_deque.sv =====
`timescale 1ns / 1ps
// A command word is taken only in idle, then decoded; the next word waits until
// the commit step loads the result word, and commit waits while the result
// register holds an unread word. A priority insert into a list neither empty
// nor full first reads and compares stored entries, reads and writes each entry
// moved and writes the new entry; all other words go from decode to commit.
// Reset clears the count, head pointer, sequencer and result valid; no sweep.
// ----------------------------------------------------------------------------
// priority_ordered_deque: bounded ordered list with priority insertion
// Holds up to DEPTH entries of payload and signed priority in a circular
// memory, and inserts or removes at most one entry per command word.
// ----------------------------------------------------------------------------
module priority_ordered_deque #(
  parameter int unsigned DEPTH          = pod_pkg::DEPTH_DEF,
  parameter int unsigned PAYLOAD_WIDTH  = pod_pkg::PAYLOAD_WIDTH_DEF,
  parameter int unsigned PRIORITY_WIDTH = pod_pkg::PRIORITY_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pod_in_if.sink    in_i,
  pod_out_if.source out_o
);

  // The controller and the datapath talk only through these two bundles.
  pod_pkg::ctrl_cmd_t  ctl_cmd;
  pod_pkg::ctrl_stat_t ctl_stat;

  // The sequencer walks each command word through its steps: decode, then for
  // a priority insert a scan from the head that reads one entry and compares it
  // in the following cycle, a shift from the tail down to the insertion place,
  // the write of the new entry, and the commit that loads the result register.
  pod_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .stat_i     (ctl_stat),
    .cmd_o      (ctl_cmd)
  );

  assign in_i.ready = ctl_cmd.in_ready;

  // The datapath keeps the entries in a circular memory so that inserts and
  // removes at either end need no shifting; only a priority insert into the
  // middle moves the entries behind its place one slot towards the tail.
  // The result register parts the two channels, so a finished word may wait
  // for the sink while the next command word is already being worked on.
  pod_dp #(
    .DEPTH          (DEPTH),
    .PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_i.valid),
    .in_command_i          (in_i.command),
    .in_payload_i          (in_i.payload),
    .in_priority_i         (in_i.priority_req),
    .ctl_i                 (ctl_cmd),
    .stat_o                (ctl_stat),
    .out_ready_i           (out_o.ready),
    .out_valid_o           (out_o.valid),
    .out_removed_payload_o (out_o.removed_payload),
    .out_removed_valid_o   (out_o.removed_valid),
    .out_status_o          (out_o.status),
    .out_entry_count_o     (out_o.entry_count),
    .out_list_empty_o      (out_o.list_empty)
  );

  // A word leaving while the result register holds an unread word would be
  // lost, and the commit must only fire when the register can take it.
  property p_no_overwrite;
    @(posedge clk_i) disable iff (!rst_ni)
      out_o.valid && !out_o.ready |=> out_o.valid;
  endproperty
  a_no_overwrite: assert property (p_no_overwrite)
    else $error("pending result word dropped before it was taken");

  property p_empty_flag;
    @(posedge clk_i) disable iff (!rst_ni)
      out_o.valid |-> (out_o.list_empty == (out_o.entry_count == '0));
  endproperty
  a_empty_flag: assert property (p_empty_flag)
    else $error("empty flag disagrees with the entry count");

  property p_removed_status;
    @(posedge clk_i) disable iff (!rst_ni)
      out_o.valid && out_o.removed_valid |-> (out_o.status == pod_pkg::ST_DONE);
  endproperty
  a_removed_status: assert property (p_removed_status)
    else $error("removed entry reported with an error status");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the priority ordered deque
// Command words go in through a queue-fed driver, and every result word is
// checked field by field against a bench-side model of the ordered list.
// The stimulus is a short directed opening, then random fill and drain runs.
// Both channels idle at random, and the result side holds off once for a
// long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned DEPTH          = pod_pkg::DEPTH_DEF;
  localparam int unsigned PW             = pod_pkg::PAYLOAD_WIDTH_DEF;
  localparam int unsigned RW             = pod_pkg::PRIORITY_WIDTH_DEF;
  localparam int unsigned CMDW           = pod_pkg::CMD_WIDTH;
  localparam int unsigned SW             = pod_pkg::STATUS_WIDTH;
  localparam int unsigned CW             = $clog2(DEPTH + 1);
  localparam int unsigned CMD_CODES_TOP  = 2 ** CMDW - 1;
  localparam int unsigned RANDOM_WORDS   = 430;
  localparam int unsigned HOLD_CYCLES    = 250;
  localparam int unsigned HOLD_AFTER     = 120;
  localparam int unsigned CALM_TAIL      = 80;
  localparam int unsigned DRAIN_CYCLES   = 80;

  // One command word as it is offered on the input channel.
  typedef struct packed {
    logic [CMDW-1:0] cmd;
    logic [PW-1:0]   payload;
    logic [RW-1:0]   rank;
  } cmd_word_t;

  // One stored entry of the list; rank is a signed priority.
  typedef struct packed {
    logic [PW-1:0] payload;
    logic [RW-1:0] rank;
  } entry_t;

  // One result word as it leaves the output channel.
  typedef struct packed {
    logic [PW-1:0] removed_payload;
    logic          removed_valid;
    logic [SW-1:0] status;
    logic [CW-1:0] entry_count;
    logic          list_empty;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pod_in_if  #(.PAYLOAD_WIDTH(PW), .PRIORITY_WIDTH(RW)) cmd_if ();
  pod_out_if #(.DEPTH(DEPTH), .PAYLOAD_WIDTH(PW))       res_if ();

  priority_ordered_deque #(
    .DEPTH          (DEPTH),
    .PAYLOAD_WIDTH  (PW),
    .PRIORITY_WIDTH (RW)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  // Free-running clock with a period of 2 ns.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bench copy of the list (index 0 is the head), the results still owed by
  // the block, and the words that are waiting to be offered.
  entry_t    held_entries[$];
  result_t   due_results[$];
  cmd_word_t pending_words[$];

  int unsigned mismatches      = 0;
  int unsigned words_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned full_drops      = 0;
  int unsigned empty_removes   = 0;
  int unsigned unused_codes    = 0;
  int unsigned peak_fill       = 0;
  int unsigned backed_up       = 0;
  int unsigned send_gap        = 0;
  int unsigned recv_gap        = 0;
  bit          word_taken      = 1'b0;
  bit          rx_hold         = 1'b0;
  bit          idle_on         = 1'b1;

  // Applies one command to the bench list and returns the result word that
  // the block owes for it. An insert by priority goes in front of the first
  // entry whose rank is not below the new one, so a new entry overtakes any
  // stored entries of equal rank. Codes above the last command are ignored.
  function automatic result_t apply_command(input cmd_word_t w);
    result_t     r;
    entry_t      e;
    int unsigned pos;
    r         = '0;
    e.payload = w.payload;
    e.rank    = w.rank;
    case (w.cmd) inside
      pod_pkg::CMD_INS_TAIL, pod_pkg::CMD_INS_HEAD, pod_pkg::CMD_INS_PRIO: begin
        if (held_entries.size() >= DEPTH) begin
          r.status = pod_pkg::ST_FULL;
        end else if (w.cmd == pod_pkg::CMD_INS_TAIL) begin
          held_entries.push_back(e);
        end else if (w.cmd == pod_pkg::CMD_INS_HEAD) begin
          held_entries.push_front(e);
        end else begin
          pos = 0;
          while (pos < held_entries.size() &&
                 $signed(w.rank) > $signed(held_entries[pos].rank)) begin
            pos++;
          end
          held_entries.insert(pos, e);
        end
      end
      pod_pkg::CMD_REM_HEAD, pod_pkg::CMD_REM_TAIL: begin
        if (held_entries.size() == 0) begin
          r.status = pod_pkg::ST_EMPTY;
        end else begin
          if (w.cmd == pod_pkg::CMD_REM_HEAD) begin
            e = held_entries.pop_front();
          end else begin
            e = held_entries.pop_back();
          end
          r.removed_payload = e.payload;
          r.removed_valid   = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = CW'(held_entries.size());
    r.list_empty  = (held_entries.size() == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Both channels are observed at the rising edge. The result side is checked
  // first; a word accepted at this same edge cannot yet have a result out,
  // since the block decodes it before the commit loads its result word.
  always @(posedge clk_i) begin
    result_t   got;
    result_t   want;
    cmd_word_t w;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got.removed_payload = res_if.removed_payload;
        got.removed_valid   = res_if.removed_valid;
        got.status          = res_if.status;
        got.entry_count     = res_if.entry_count;
        got.list_empty      = res_if.list_empty;
        if (due_results.size() == 0) begin
          $error("result word with nothing outstanding: 'h%0h", got);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          results_checked++;
          check_field("removed_payload", 32'(want.removed_payload),
                      32'(got.removed_payload));
          check_field("removed_valid", 32'(want.removed_valid), 32'(got.removed_valid));
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
          check_field("list_empty", 32'(want.list_empty), 32'(got.list_empty));
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        w.cmd     = cmd_if.command;
        w.payload = cmd_if.payload;
        w.rank    = cmd_if.priority_req;
        want      = apply_command(w);
        due_results.push_back(want);
        words_sent++;
        word_taken = 1'b1;
        if (want.status == pod_pkg::ST_FULL) full_drops++;
        if (want.status == pod_pkg::ST_EMPTY) empty_removes++;
        if (w.cmd > pod_pkg::CMD_REM_TAIL) unused_codes++;
        if (held_entries.size() > peak_fill) peak_fill = held_entries.size();
      end
      if (rx_hold && cmd_if.valid && !cmd_if.ready) backed_up++;
    end
  end

  // Command driver: moves on to the next word only once the current one has
  // been taken, so valid never drops while a word is still on offer. After a
  // word it may leave a random gap before the next one.
  always @(negedge clk_i) begin
    cmd_word_t w;
    if (rst_ni && (!cmd_if.valid || word_taken)) begin
      word_taken = 1'b0;
      if (send_gap != 0 || pending_words.size() == 0) begin
        if (send_gap != 0) send_gap--;
        cmd_if.valid <= 1'b0;
      end else begin
        w = pending_words.pop_front();
        cmd_if.valid        <= 1'b1;
        cmd_if.command      <= w.cmd;
        cmd_if.payload      <= w.payload;
        cmd_if.priority_req <= w.rank;
        if (idle_on && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 13);
      end
    end
  end

  // Result receiver: random stalls in bursts, and the long hold-off below.
  always @(negedge clk_i) begin
    if (rx_hold) begin
      res_if.ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 13);
    end
  end

  // Once the run is under way the receiver stops taking results for a long
  // stretch, while the driver keeps offering words, so the block backs up.
  initial begin
    while (words_sent < HOLD_AFTER) @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  task automatic queue_word(input logic [CMDW-1:0] cmd, input logic [PW-1:0] payload,
                            input logic [RW-1:0] rank);
    cmd_word_t w;
    w.cmd     = cmd;
    w.payload = payload;
    w.rank    = rank;
    pending_words.push_back(w);
  endtask

  // Ranks lean towards the two extremes and a narrow band around zero, so
  // that ties between stored entries turn up often.
  function automatic logic [RW-1:0] random_rank();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(RW-1){1'b0}}};
      1:       return {1'b0, {(RW-1){1'b1}}};
      2, 3, 4: return RW'($signed($urandom_range(0, 6)) - 3);
      default: return RW'($urandom());
    endcase
  endfunction

  initial begin
    int unsigned      made;
    int unsigned      bias;
    int unsigned      run_len;
    int unsigned      pick;
    int unsigned      total;
    logic [CMDW-1:0]  c;

    rst_ni              = 1'b0;
    cmd_if.valid        = 1'b0;
    cmd_if.command      = '0;
    cmd_if.payload      = '0;
    cmd_if.priority_req = '0;
    res_if.ready        = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Removes from an empty list, with stray data on the unused fields.
    queue_word(pod_pkg::CMD_REM_HEAD, 16'hFFFF, 16'h7FFF);
    queue_word(pod_pkg::CMD_REM_TAIL, 16'h0000, 16'h8000);
    // Priority inserts at the extremes and at zero, then ties at both ends.
    queue_word(pod_pkg::CMD_INS_PRIO, 16'hFFFF, 16'h8000);
    queue_word(pod_pkg::CMD_INS_PRIO, 16'h0000, 16'h7FFF);
    queue_word(pod_pkg::CMD_INS_PRIO, 16'h1234, 16'h0000);
    queue_word(pod_pkg::CMD_INS_PRIO, 16'hA5A5, 16'h7FFF);
    queue_word(pod_pkg::CMD_INS_PRIO, 16'h5A5A, 16'h8000);
    queue_word(pod_pkg::CMD_INS_HEAD, 16'hBEEF, 16'h0001);
    queue_word(pod_pkg::CMD_INS_TAIL, 16'hCAFE, 16'hFFFF);
    // Unused command codes must leave the list alone.
    for (int u = pod_pkg::CMD_REM_TAIL + 1; u <= CMD_CODES_TOP; u++) begin
      queue_word(CMDW'(u), 16'h8001, 16'h7FFE);
    end
    // Fill the list to the brim, then try each insert on a full list.
    for (int i = 7; i < DEPTH; i++) begin
      queue_word(pod_pkg::CMD_INS_PRIO, PW'($urandom()), random_rank());
    end
    queue_word(pod_pkg::CMD_INS_TAIL, 16'h0F0F, 16'h0000);
    queue_word(pod_pkg::CMD_INS_HEAD, 16'hF0F0, 16'h8000);
    queue_word(pod_pkg::CMD_INS_PRIO, 16'h3C3C, 16'h7FFF);
    queue_word(pod_pkg::CMD_REM_HEAD, 16'h0000, 16'h0000);
    queue_word(pod_pkg::CMD_REM_TAIL, 16'h0000, 16'h0000);

    // Random part in runs that lean towards filling, draining or neither, so
    // that the fill level sweeps between empty and full many times.
    made = 0;
    while (made < RANDOM_WORDS) begin
      case ($urandom_range(0, 2))
        0:       bias = 85;
        1:       bias = 15;
        default: bias = 48;
      endcase
      run_len = $urandom_range(8, 30);
      for (int i = 0; i < run_len && made < RANDOM_WORDS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          c = CMDW'($urandom_range(pod_pkg::CMD_REM_TAIL + 1, CMD_CODES_TOP));
        end else if (pick < 4 + bias) begin
          c = CMDW'($urandom_range(pod_pkg::CMD_INS_TAIL, pod_pkg::CMD_INS_PRIO));
        end else begin
          c = CMDW'($urandom_range(pod_pkg::CMD_REM_HEAD, pod_pkg::CMD_REM_TAIL));
        end
        queue_word(c, PW'($urandom()), random_rank());
        if (c <= pod_pkg::CMD_REM_TAIL) made++;
      end
    end
    total = pending_words.size();

    // The last stretch runs at full rate on both sides.
    while (words_sent < total - CALM_TAIL) @(posedge clk_i);
    idle_on = 1'b0;
    while (words_sent < total || due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d result words for %0d command words: %0d inserts dropped when full,",
             results_checked, words_sent, full_drops);
    $display("%0d removes on empty, %0d unused codes, peak fill %0d of %0d, %0d backed-up cycles.",
             empty_removes, unused_codes, peak_fill, DEPTH, backed_up);
    if (mismatches == 0) begin
      $display("[priority_ordered_deque] OK");
    end else begin
      $display("[priority_ordered_deque] ERROR");
    end
    $finish;
  end

  // Safety net against a hung block; far longer than the slowest correct run.
  initial begin
    #400_000;
    $display("[priority_ordered_deque] ERROR");
    $finish;
  end

endmodule
